[src/pcdm_pkg.sv]
package pcdm_pkg;

	// Field widths of the capture timestamps and the results.
	localparam int unsigned TIME_W = 16;
	localparam int unsigned RATE_W = 28;
	localparam int unsigned DUTY_W = 7;

	// The shared divider takes a 28-bit dividend and a 16-bit divisor, one bit a step.
	localparam int unsigned DVD_W     = 28;
	localparam int unsigned DVS_W     = 16;
	localparam int unsigned DIV_STEPS = DVD_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	// Duty is saturated at this value, and the width is scaled by it.
	localparam int unsigned DUTY_MAX = 100;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_TICK_RATE_A = 2'd0;
	localparam logic [1:0] REG_WRAP_TOP_A  = 2'd1;
	localparam logic [1:0] REG_TICK_RATE_B = 2'd2;
	localparam logic [1:0] REG_WRAP_TOP_B  = 2'd3;

	// Input commands.
	localparam logic CMD_RISE_PAIR = 1'b0;
	localparam logic CMD_FALL_PAIR = 1'b1;

	typedef struct packed {
		logic              command;
		logic [1:0]        channel;
		logic [TIME_W-1:0] time_first;
		logic [TIME_W-1:0] time_second;
	} in_req_t;

	typedef struct packed {
		logic [1:0]        out_channel;
		logic [TIME_W-1:0] period_ticks;
		logic [RATE_W-1:0] frequency_hz;
		logic [TIME_W-1:0] pulse_width_ticks;
		logic [DUTY_W-1:0] duty_percent;
		logic              zero_period;
	} out_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_FREQ,
		ST_DUTY,
		ST_DONE
	} state_t;

	// Handshake between the sequencer and the divider.
	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_cmd_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_sts_t;

endpackage

[src/pcdm_div.sv]
module pcdm_div (
	input  logic                clk,
	input  logic                arst_n,
	input  pcdm_pkg::div_cmd_t  cmd,
	output pcdm_pkg::div_sts_t  sts
);

	logic [pcdm_pkg::DVD_W-1:0]     dvd_q;
	logic [pcdm_pkg::DVS_W-1:0]     dvs_q;
	logic [pcdm_pkg::DVS_W-1:0]     rem_q;
	logic [pcdm_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [pcdm_pkg::DVS_W:0]   rem_sh;
	logic                       qbit;
	logic [pcdm_pkg::DVS_W-1:0] rem_next;

	// One restoring step: shift in the next dividend bit and try the subtraction.
	always_comb begin
		rem_sh   = {rem_q, dvd_q[pcdm_pkg::DVD_W-1]};
		qbit     = (rem_sh >= {1'b0, dvs_q});
		rem_next = qbit ? pcdm_pkg::DVS_W'(rem_sh - {1'b0, dvs_q})
		                : pcdm_pkg::DVS_W'(rem_sh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == pcdm_pkg::DIV_CNT_W'(pcdm_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dvd_q <= cmd.dividend;
			dvs_q <= cmd.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[pcdm_pkg::DVD_W-2:0], qbit};
			rem_q <= rem_next;
		end
	end

	assign sts.busy     = busy_q;
	assign sts.done     = done_q;
	assign sts.quotient = dvd_q;

endmodule

[src/pwm_capture_period_duty_meter_top.sv]
// Each accepted request for a built channel with a nonzero period passes through the update
// state, two 28-step divisions in one shared restoring divider and then the result state;
// a zero period or an unbuilt channel goes from the update state straight to the result state.
// One request at a time: in_stall is high until the result is taken.
// Reset (arst_n low, asynchronous): sequencer idle, registers at their defaults, all stored
// rise edges, periods and widths cleared to zero.
module pwm_capture_period_duty_meter_top #(
	parameter int CHANNELS = 4
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	output logic                in_stall,
	input  pcdm_pkg::in_req_t   in_req,

	output logic                out_valid,
	input  logic                out_stall,
	output pcdm_pkg::out_rsp_t  out_rsp,

	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	// Index width into the per-channel stores; at least one bit even for a single channel.
	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// ------------------------------------------------------------------
	// Configuration registers. Channels 0 and 1 use group A, channels 2 and 3 group B.
	// ------------------------------------------------------------------
	logic [pcdm_pkg::RATE_W-1:0] rate_a_q;
	logic [pcdm_pkg::TIME_W-1:0] top_a_q;
	logic [pcdm_pkg::RATE_W-1:0] rate_b_q;
	logic [pcdm_pkg::TIME_W-1:0] top_b_q;
	logic                        cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_a_q <= pcdm_pkg::RATE_W'(1000000);
			top_a_q  <= pcdm_pkg::TIME_W'(65535);
			rate_b_q <= pcdm_pkg::RATE_W'(1000000);
			top_b_q  <= pcdm_pkg::TIME_W'(65535);
		end else if (cfg_we) begin
			case (paddr[3:2])
				pcdm_pkg::REG_TICK_RATE_A: rate_a_q <= pwdata[pcdm_pkg::RATE_W-1:0];
				pcdm_pkg::REG_WRAP_TOP_A:  top_a_q  <= pwdata[pcdm_pkg::TIME_W-1:0];
				pcdm_pkg::REG_TICK_RATE_B: rate_b_q <= pwdata[pcdm_pkg::RATE_W-1:0];
				pcdm_pkg::REG_WRAP_TOP_B:  top_b_q  <= pwdata[pcdm_pkg::TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			pcdm_pkg::REG_TICK_RATE_A: prdata = 32'(rate_a_q);
			pcdm_pkg::REG_WRAP_TOP_A:  prdata = 32'(top_a_q);
			pcdm_pkg::REG_TICK_RATE_B: prdata = 32'(rate_b_q);
			pcdm_pkg::REG_WRAP_TOP_B:  prdata = 32'(top_b_q);
			default:                   prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer state and the captured request.
	// ------------------------------------------------------------------
	pcdm_pkg::state_t  state_q, state_d;
	pcdm_pkg::in_req_t req_q;

	// Per-channel stores, each entry read and written only at the current request's channel.
	logic [pcdm_pkg::TIME_W-1:0] rise_start_q   [CHANNELS];
	logic [pcdm_pkg::TIME_W-1:0] rise_end_q     [CHANNELS];
	logic [pcdm_pkg::TIME_W-1:0] period_store_q [CHANNELS];
	logic [pcdm_pkg::TIME_W-1:0] width_store_q  [CHANNELS];

	// Working values of the request in flight.
	logic [pcdm_pkg::TIME_W-1:0] per_q;
	logic [pcdm_pkg::TIME_W-1:0] wid_q;
	logic [pcdm_pkg::RATE_W-1:0] freq_q;
	logic [pcdm_pkg::DUTY_W-1:0] duty_q;
	logic                        zp_q;

	pcdm_pkg::div_cmd_t div_cmd;
	pcdm_pkg::div_sts_t div_sts;

	// Channel decode. A channel beyond the built ones leaves the stores alone.
	logic [IDX_W+1:0]            ch_ext;
	logic [IDX_W-1:0]            idx;
	logic                        ch_ok;
	logic                        grp_b;
	logic [pcdm_pkg::RATE_W-1:0] rate_sel;
	logic [pcdm_pkg::TIME_W-1:0] top_sel;

	assign ch_ext   = (IDX_W + 2)'(req_q.channel);
	assign idx      = ch_ext[IDX_W-1:0];
	assign ch_ok    = int'(req_q.channel) < CHANNELS;
	assign grp_b    = req_q.channel[1];
	assign rate_sel = grp_b ? rate_b_q : rate_a_q;
	assign top_sel  = grp_b ? top_b_q : top_a_q;

	// Period of a rise pair. When the first edge is later, the timer wrapped at its top;
	// a negative result (top set too small) clamps to zero. The sum never exceeds 16 bits.
	logic [pcdm_pkg::TIME_W+1:0] wrap_sum;
	logic [pcdm_pkg::TIME_W-1:0] rise_period;

	always_comb begin
		wrap_sum = (pcdm_pkg::TIME_W + 2)'(top_sel) + (pcdm_pkg::TIME_W + 2)'(req_q.time_second)
		         - (pcdm_pkg::TIME_W + 2)'(req_q.time_first);
		if (req_q.time_first > req_q.time_second) begin
			rise_period = wrap_sum[pcdm_pkg::TIME_W+1] ? '0 : wrap_sum[pcdm_pkg::TIME_W-1:0];
		end else begin
			rise_period = req_q.time_second - req_q.time_first;
		end
	end

	// Width of a fall pair: the first fall edge inside the stored rise interval wins,
	// measured from the rising edge. With neither inside, the stored width stays.
	logic [pcdm_pkg::TIME_W-1:0] s_rd, e_rd;
	logic                        first_in, second_in;
	logic [pcdm_pkg::TIME_W-1:0] new_period, new_width;

	always_comb begin
		s_rd      = rise_start_q[idx];
		e_rd      = rise_end_q[idx];
		first_in  = (req_q.time_first >= s_rd) && (req_q.time_first <= e_rd);
		second_in = (req_q.time_second >= s_rd) && (req_q.time_second <= e_rd);
		new_period = period_store_q[idx];
		new_width  = width_store_q[idx];
		if (req_q.command == pcdm_pkg::CMD_RISE_PAIR) begin
			new_period = rise_period;
		end else if (first_in) begin
			new_width = req_q.time_first - s_rd;
		end else if (second_in) begin
			new_width = req_q.time_second - s_rd;
		end
	end

	// width * 100 as shifts and adds: 64 + 32 + 4. At most 23 bits.
	logic [pcdm_pkg::DVD_W-1:0] wid_ext;
	logic [pcdm_pkg::DVD_W-1:0] wid_x100;

	assign wid_ext  = pcdm_pkg::DVD_W'(wid_q);
	assign wid_x100 = (wid_ext << 6) + (wid_ext << 5) + (wid_ext << 2);

	// Next state and divider commands. For a built channel with a nonzero period the divider is
	// loaded twice per request: first with tick rate over period, then with scaled width over period.
	always_comb begin
		state_d          = state_q;
		div_cmd.start    = 1'b0;
		div_cmd.dividend = pcdm_pkg::DVD_W'(rate_sel);
		div_cmd.divisor  = new_period;
		case (state_q)
			pcdm_pkg::ST_IDLE: begin
				if (in_valid) state_d = pcdm_pkg::ST_UPD;
			end
			pcdm_pkg::ST_UPD: begin
				if (!ch_ok || new_period == '0) begin
					state_d = pcdm_pkg::ST_DONE;
				end else begin
					div_cmd.start = 1'b1;
					state_d       = pcdm_pkg::ST_FREQ;
				end
			end
			pcdm_pkg::ST_FREQ: begin
				div_cmd.dividend = wid_x100;
				div_cmd.divisor  = per_q;
				if (div_sts.done) begin
					div_cmd.start = 1'b1;
					state_d       = pcdm_pkg::ST_DUTY;
				end
			end
			pcdm_pkg::ST_DUTY: begin
				if (div_sts.done) state_d = pcdm_pkg::ST_DONE;
			end
			pcdm_pkg::ST_DONE: begin
				if (!out_stall) state_d = pcdm_pkg::ST_IDLE;
			end
			default: state_d = pcdm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcdm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Store updates happen in the update state of a request for a built channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				rise_start_q[i]   <= '0;
				rise_end_q[i]     <= '0;
				period_store_q[i] <= '0;
				width_store_q[i]  <= '0;
			end
		end else if (state_q == pcdm_pkg::ST_UPD && ch_ok) begin
			if (req_q.command == pcdm_pkg::CMD_RISE_PAIR) begin
				rise_start_q[idx] <= req_q.time_first;
				rise_end_q[idx]   <= req_q.time_second;
			end
			period_store_q[idx] <= new_period;
			width_store_q[idx]  <= new_width;
		end
	end

	// Payload registers of the request in flight.
	always_ff @(posedge clk) begin
		case (state_q)
			pcdm_pkg::ST_IDLE: begin
				if (in_valid) req_q <= in_req;
			end
			pcdm_pkg::ST_UPD: begin
				// Zero frequency and duty are final for a zero period or unbuilt channel.
				per_q  <= ch_ok ? new_period : '0;
				wid_q  <= ch_ok ? new_width : '0;
				freq_q <= '0;
				duty_q <= '0;
				zp_q   <= !ch_ok || (new_period == '0);
			end
			pcdm_pkg::ST_FREQ: begin
				if (div_sts.done) freq_q <= div_sts.quotient;
			end
			pcdm_pkg::ST_DUTY: begin
				if (div_sts.done) begin
					duty_q <= (div_sts.quotient > pcdm_pkg::DVD_W'(pcdm_pkg::DUTY_MAX))
					          ? pcdm_pkg::DUTY_W'(pcdm_pkg::DUTY_MAX)
					          : div_sts.quotient[pcdm_pkg::DUTY_W-1:0];
				end
			end
			default: ;
		endcase
	end

	pcdm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.sts    (div_sts)
	);

	// Handshakes: a new request is taken only while idle; the result is held until taken.
	assign in_stall  = (state_q != pcdm_pkg::ST_IDLE);
	assign out_valid = (state_q == pcdm_pkg::ST_DONE);

	assign out_rsp.out_channel       = req_q.channel;
	assign out_rsp.period_ticks      = per_q;
	assign out_rsp.frequency_hz      = freq_q;
	assign out_rsp.pulse_width_ticks = wid_q;
	assign out_rsp.duty_percent      = duty_q;
	assign out_rsp.zero_period       = zp_q;

	// The divider must be quiet while the sequencer is idle or holding a result.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pcdm_pkg::ST_IDLE || state_q == pcdm_pkg::ST_DONE) |-> !div_sts.busy)
		else $error("divider busy outside a division phase");

	// A zero-period result reports no frequency and no duty.
	a_zero_period: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_rsp.zero_period) |->
		(out_rsp.frequency_hz == '0 && out_rsp.duty_percent == '0))
		else $error("zero period with nonzero frequency or duty");

	// Duty never exceeds its saturation value.
	a_duty_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_rsp.duty_percent <= pcdm_pkg::DUTY_W'(pcdm_pkg::DUTY_MAX)))
		else $error("duty above saturation");

	// A division completes only in a phase that consumes its quotient.
	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (state_q == pcdm_pkg::ST_FREQ || state_q == pcdm_pkg::ST_DUTY))
		else $error("divider finished outside a division phase");

endmodule
